/* rtl/hncs_pkg.sv */
`default_nettype none
package hncs_pkg;

   localparam int NUM_CLASSES_DEF = 8;
   localparam int MAX_WORDS_DEF   = 512;

   localparam int DATA_W      = 32;
   localparam int CLASS_SEL_W = 3;
   localparam int WORD_SEL_W  = 9;
   localparam int COUNT_CFG_W = 10;
   localparam int DIST_W      = 15;

   localparam logic [COUNT_CFG_W-1:0] WORD_COUNT_RESET = 10'd314;
   localparam logic [DIST_W-1:0]      DIST_MAX         = 15'h7FFF;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic load_wr;
      logic query_start;
      logic issue;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic issue_last;
      logic busy;
      logic final_word;
   } dp_status_type;

endpackage
`default_nettype wire

/* rtl/hncs_req_if.sv */
`default_nettype none
interface hncs_req_if;
   logic                                valid;
   logic                                ready;
   logic                                opcode;
   logic [hncs_pkg::CLASS_SEL_W-1:0]    class_sel;
   logic [hncs_pkg::WORD_SEL_W-1:0]     word_sel;
   logic [hncs_pkg::DATA_W-1:0]         data_word;

   modport source (output valid, opcode, class_sel, word_sel, data_word, input ready);
   modport sink   (input valid, opcode, class_sel, word_sel, data_word, output ready);
endinterface
`default_nettype wire

/* rtl/hncs_rsp_if.sv */
`default_nettype none
interface hncs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [hncs_pkg::CLASS_SEL_W-1:0]    best_class;
   logic [hncs_pkg::DIST_W-1:0]         best_distance;

   modport source (output valid, best_class, best_distance, input ready);
   modport sink   (input valid, best_class, best_distance, output ready);
endinterface
`default_nettype wire

/* rtl/hncs_csr_if.sv */
`default_nettype none
interface hncs_csr_if;
   logic                                valid;
   logic                                ready;
   logic [hncs_pkg::COUNT_CFG_W-1:0]    word_count;

   modport source (output valid, word_count, input ready);
   modport sink   (input valid, word_count, output ready);
endinterface
`default_nettype wire

/* rtl/hncs_ctrl.sv */
`default_nettype none
module hncs_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_opcode,
   output logic                         req_ready,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output hncs_pkg::ctrl_cmd_type       cmd,
   input  wire hncs_pkg::dp_status_type status
);

   typedef enum logic [1:0] {
      IDLE,
      ISSUE,
      DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_accept;
   logic      slot_free;

   assign req_ready  = (state_ff == IDLE);
   assign req_accept = req_valid && req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      state_in         = state_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      cmd.load_wr      = 1'b0;
      cmd.query_start  = 1'b0;
      cmd.issue        = 1'b0;
      cmd.finish       = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (req_accept) begin
               if (req_opcode == hncs_pkg::OP_QUERY) begin
                  cmd.query_start = 1'b1;
                  state_in        = ISSUE;
               end else begin
                  cmd.load_wr = 1'b1;
               end
            end
         end
         ISSUE: begin
            cmd.issue = 1'b1;
            if (status.issue_last) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            // a final word waits here until the result register has room
            if (!status.busy && (!status.final_word || slot_free)) begin
               cmd.finish = 1'b1;
               state_in   = IDLE;
               if (status.final_word) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/hncs_datapath.sv */
`default_nettype none
module hncs_datapath #(
   parameter int NUM_CLASSES = hncs_pkg::NUM_CLASSES_DEF,
   parameter int MAX_WORDS   = hncs_pkg::MAX_WORDS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   hncs_csr_if.sink                               csr_ch,
   input  wire logic [hncs_pkg::CLASS_SEL_W-1:0]  req_class_sel,
   input  wire logic [hncs_pkg::WORD_SEL_W-1:0]   req_word_sel,
   input  wire logic [hncs_pkg::DATA_W-1:0]       req_data_word,
   input  wire hncs_pkg::ctrl_cmd_type            cmd,
   output hncs_pkg::dp_status_type                status,
   output logic [hncs_pkg::CLASS_SEL_W-1:0]       best_class,
   output logic [hncs_pkg::DIST_W-1:0]            best_distance
);

   localparam int ClassIdxW = $clog2(NUM_CLASSES);
   localparam int WordIdxW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int MemAddrW  = ClassIdxW + WordIdxW;
   localparam int MemDepth  = NUM_CLASSES << WordIdxW;
   localparam int CountW    = $clog2(MAX_WORDS + 1);
   localparam int CmpW      = (CountW > hncs_pkg::COUNT_CFG_W) ? CountW : hncs_pkg::COUNT_CFG_W;
   localparam int DataW     = hncs_pkg::DATA_W;
   localparam int DistW     = hncs_pkg::DIST_W;
   localparam int SumW      = DistW + 1;
   localparam int OnesW     = 6;

   localparam logic [DataW-1:0] PopM1 = 32'h5555_5555;
   localparam logic [DataW-1:0] PopM2 = 32'h3333_3333;
   localparam logic [DataW-1:0] PopM4 = 32'h0F0F_0F0F;

   function automatic logic [OnesW-1:0] ones_in(input logic [DataW-1:0] v);
      logic [DataW-1:0] a;
      logic [DataW-1:0] b;
      logic [DataW-1:0] c;
      a = v - ((v >> 1) & PopM1);
      b = (a & PopM2) + ((a >> 2) & PopM2);
      c = (b + (b >> 4)) & PopM4;
      return OnesW'(c[7:0] + c[15:8] + c[23:16] + c[31:24]);
   endfunction

   logic [DataW-1:0]                   mem [MemDepth];
   logic [hncs_pkg::COUNT_CFG_W-1:0]   word_count_ff;
   logic [DataW-1:0]                   query_ff;
   logic                               final_ff, final_in;
   logic [WordIdxW-1:0]                pos_ff;
   logic [ClassIdxW-1:0]               cls_cnt_ff;
   logic                               s1_valid_ff;
   logic [ClassIdxW-1:0]               s1_cls_ff;
   logic [DataW-1:0]                   rd_data_ff;
   logic                               s2_valid_ff;
   logic [ClassIdxW-1:0]               s2_cls_ff;
   logic [OnesW-1:0]                   s2_ones_ff;
   logic [DistW-1:0]                   dist_ff [NUM_CLASSES];
   logic [ClassIdxW-1:0]               best_cls_ff;
   logic [DistW-1:0]                   best_dist_ff;
   logic [hncs_pkg::CLASS_SEL_W-1:0]   out_class_ff;
   logic [DistW-1:0]                   out_dist_ff;

   logic [31:0]                        load_cls_ext;
   logic [31:0]                        load_word_ext;
   logic                               load_in_range;
   logic [MemAddrW-1:0]                wr_addr;
   logic [MemAddrW-1:0]                rd_addr;
   logic [CmpW-1:0]                    wc_ext;
   logic [CmpW-1:0]                    count_use;
   logic [CmpW-1:0]                    pos_next;
   logic [SumW-1:0]                    sum;
   logic [DistW-1:0]                   dist_sat;
   logic [31:0]                        best_cls_ext;

   assign csr_ch.ready = 1'b1;

   assign load_cls_ext  = 32'(req_class_sel);
   assign load_word_ext = 32'(req_word_sel);
   assign load_in_range = (load_cls_ext < 32'(NUM_CLASSES)) && (load_word_ext < 32'(MAX_WORDS));
   assign wr_addr       = {load_cls_ext[ClassIdxW-1:0], load_word_ext[WordIdxW-1:0]};
   assign rd_addr       = {cls_cnt_ff, pos_ff};

   // zero count acts as one, count above the store depth saturates
   always_comb begin
      wc_ext = CmpW'(word_count_ff);
      if (wc_ext == '0) begin
         count_use = CmpW'(1);
      end else if (wc_ext > CmpW'(MAX_WORDS)) begin
         count_use = CmpW'(MAX_WORDS);
      end else begin
         count_use = wc_ext;
      end
      pos_next = CmpW'(pos_ff) + CmpW'(1);
      final_in = !(pos_next < count_use);
   end

   assign sum      = {1'b0, dist_ff[s2_cls_ff]} + SumW'(s2_ones_ff);
   assign dist_sat = sum[DistW] ? hncs_pkg::DIST_MAX : sum[DistW-1:0];

   assign status.issue_last = (cls_cnt_ff == ClassIdxW'(NUM_CLASSES - 1));
   assign status.busy       = s1_valid_ff || s2_valid_ff;
   assign status.final_word = final_ff;

   assign best_cls_ext  = 32'(best_cls_ff);
   assign best_class    = out_class_ff;
   assign best_distance = out_dist_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_wr && load_in_range) begin
         mem[wr_addr] <= req_data_word;
      end
      if (cmd.issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_count_ff <= hncs_pkg::WORD_COUNT_RESET;
         pos_ff        <= '0;
         cls_cnt_ff    <= '0;
         final_ff      <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            dist_ff[i] <= '0;
         end
      end else begin
         if (csr_ch.valid) begin
            word_count_ff <= csr_ch.word_count;
         end
         if (cmd.query_start) begin
            final_ff   <= final_in;
            cls_cnt_ff <= '0;
         end else if (cmd.issue) begin
            cls_cnt_ff <= cls_cnt_ff + ClassIdxW'(1);
         end
         if (cmd.finish) begin
            pos_ff <= final_ff ? '0 : pos_ff + WordIdxW'(1);
         end
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         if (s2_valid_ff) begin
            // the last word of a query clears each distance as it is ranked
            dist_ff[s2_cls_ff] <= final_ff ? '0 : dist_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         query_ff <= req_data_word;
      end
      s1_cls_ff  <= cls_cnt_ff;
      s2_cls_ff  <= s1_cls_ff;
      s2_ones_ff <= ones_in(query_ff ^ rd_data_ff);
      // classes arrive in ascending order, strict compare keeps the lowest on ties
      if (s2_valid_ff && final_ff && ((s2_cls_ff == '0) || (dist_sat < best_dist_ff))) begin
         best_cls_ff  <= s2_cls_ff;
         best_dist_ff <= dist_sat;
      end
      if (cmd.finish && final_ff) begin
         out_class_ff <= best_cls_ext[hncs_pkg::CLASS_SEL_W-1:0];
         out_dist_ff  <= best_dist_ff;
      end
   end

endmodule
`default_nettype wire

/* rtl/hamming_nearest_class_search.sv */
// Nearest-class search by Hamming distance over stored hypervectors.
// req_ch: one transaction per item. opcode load writes data_word into the
//   store at (class_sel, word_sel); out-of-range loads are dropped. opcode
//   query carries the next 32-bit word of a query hypervector.
// csr_ch: writes word_count, the number of words per query; always ready,
//   write it only while the block is idle.
// rsp_ch: after the last query word, one transaction with the class of
//   smallest distance (lowest index on ties) and that distance.
// Timing: a load is written without leaving idle. The single store read port
//   delivers one class word per cycle, followed by a two-stage
//   popcount/accumulate pipeline. The result is valid on the cycle after the
//   final word completes.
// Stall: the result sits in an output register; new words are accepted while
//   it waits, but a further final word holds until the register is taken.
// Reset: distances and query position clear, word_count returns to 314,
//   the pending result is dropped; the store keeps its contents and is
//   undefined until written.
`default_nettype none
module hamming_nearest_class_search #(
   parameter int NUM_CLASSES = hncs_pkg::NUM_CLASSES_DEF,
   parameter int MAX_WORDS   = hncs_pkg::MAX_WORDS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   hncs_req_if.sink   req_ch,
   hncs_rsp_if.source rsp_ch,
   hncs_csr_if.sink   csr_ch
);

   hncs_pkg::ctrl_cmd_type  cmd;
   hncs_pkg::dp_status_type status;
   logic                    req_ready;
   logic                    rsp_valid;

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

   hncs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ready),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd),
      .status     (status)
   );

   hncs_datapath #(
      .NUM_CLASSES (NUM_CLASSES),
      .MAX_WORDS   (MAX_WORDS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_ch        (csr_ch),
      .req_class_sel (req_ch.class_sel),
      .req_word_sel  (req_ch.word_sel),
      .req_data_word (req_ch.data_word),
      .cmd           (cmd),
      .status        (status),
      .best_class    (rsp_ch.best_class),
      .best_distance (rsp_ch.best_distance)
   );

endmodule
`default_nettype wire
